// ===== rtl/phm_pkg.sv =====
`timescale 1ns / 1ps

package phm_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int COUNT_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int DEPTH      = 1 << PIXEL_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_CLEAR = 2'd0;
    localparam kind_t KIND_PIXEL = 2'd1;
    localparam kind_t KIND_READ  = 2'd2;

    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] bin_count;
        logic [FIELD_BITS-1:0] peak_count;
        logic [FIELD_BITS-1:0] peak_bin;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_FETCH,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic finish;
        logic sweep;
        logic clear_done;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
    } status_t;

endpackage

// ===== rtl/pixel_histogram_with_mode_top.sv =====
`timescale 1ns / 1ps

// pixel histogram with running peak bin
// request channel: req_valid / req_stall / req carries kind and value
// kind clear zeroes all bins and the peak, kind pixel adds one to a bin (saturating),
// kind read returns a bin count; every request gives exactly one response
// response channel: rsp_valid / rsp_stall / rsp carries bin count, peak count
// and peak bin
// pixel and read requests: the bin memory read is registered on acceptance, the
// update is written back in the next cycle and the response is valid in the
// response state after that
// one request in flight: a new request is taken the cycle after the response
// is accepted
// clear walks all 65536 bin memory entries one entry a cycle, then gives the
// all-zero response
// after reset the same walk runs over the bin memory before req_stall drops
// while rsp_stall is high the response holds and req_stall stays high

module pixel_histogram_with_mode_top
    import phm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t    cmd;
    status_t status;

    phm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    phm_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

// ===== rtl/phm_ctrl.sv =====
`timescale 1ns / 1ps

module phm_ctrl
    import phm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  kind_t   req_kind,
    output logic    req_stall,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg;
    state_t state_next;
    logic   from_clear_reg;
    logic   from_clear_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            from_clear_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            from_clear_reg <= from_clear_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        from_clear_next = from_clear_reg;
        cmd             = '0;
        req_stall       = 1'b1;
        rsp_valid       = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    if (from_clear_reg)
                    begin
                        cmd.clear_done = 1'b1;
                        state_next     = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    if (req_kind == KIND_CLEAR)
                    begin
                        from_clear_next = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/phm_datapath.sv =====
`timescale 1ns / 1ps

module phm_datapath
    import phm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    req,
    input  cmd_t    cmd,
    output status_t status,
    output rsp_t    rsp
);

    logic [COUNT_BITS-1:0] mem [DEPTH];

    logic [PIXEL_BITS-1:0] addr_reg;
    logic [PIXEL_BITS-1:0] addr_next;
    logic [COUNT_BITS-1:0] peak_count_reg;
    logic [COUNT_BITS-1:0] peak_count_next;
    logic [PIXEL_BITS-1:0] peak_bin_reg;
    logic [PIXEL_BITS-1:0] peak_bin_next;

    logic [PIXEL_BITS-1:0] idx_reg;
    kind_t                 kind_reg;
    logic [COUNT_BITS-1:0] rd_reg;
    logic [COUNT_BITS-1:0] res_count_reg;
    logic [COUNT_BITS-1:0] res_count_next;

    logic [COUNT_BITS-1:0] inc;
    logic                  sat;
    logic                  mem_we;
    logic [PIXEL_BITS-1:0] mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    logic [PIXEL_BITS-1:0] req_idx;

    assign req_idx = req.value[PIXEL_BITS-1:0];
    assign inc     = rd_reg + COUNT_BITS'(1);
    assign sat     = (rd_reg == COUNT_MAX);

    assign mem_we = cmd.sweep || (cmd.finish && (kind_reg == KIND_PIXEL) && !sat);
    assign mem_wa = cmd.sweep ? addr_reg : idx_reg;
    assign mem_wd = cmd.sweep ? '0 : inc;

    assign status.sweep_last = &addr_reg;

    always_comb
    begin
        addr_next       = addr_reg;
        peak_count_next = peak_count_reg;
        peak_bin_next   = peak_bin_reg;
        res_count_next  = res_count_reg;
        if (cmd.sweep)
        begin
            addr_next = addr_reg + PIXEL_BITS'(1);
        end
        if (cmd.clear_done)
        begin
            peak_count_next = '0;
            peak_bin_next   = '0;
            res_count_next  = '0;
        end
        if (cmd.finish)
        begin
            case (kind_reg)
                KIND_PIXEL:
                begin
                    if (sat)
                    begin
                        res_count_next = rd_reg;
                    end
                    else
                    begin
                        res_count_next = inc;
                        if (inc > peak_count_reg)
                        begin
                            peak_count_next = inc;
                            peak_bin_next   = idx_reg;
                        end
                    end
                end
                KIND_READ:
                begin
                    res_count_next = rd_reg;
                end
                default:
                begin
                    res_count_next = '0;
                end
            endcase
        end
    end

    // bin memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.capture)
        begin
            rd_reg <= mem[req_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            peak_count_reg <= '0;
            peak_bin_reg   <= '0;
        end
        else
        begin
            addr_reg       <= addr_next;
            peak_count_reg <= peak_count_next;
            peak_bin_reg   <= peak_bin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= req_idx;
            kind_reg <= req.kind;
        end
        res_count_reg <= res_count_next;
    end

    assign rsp.bin_count  = FIELD_BITS'(res_count_reg);
    assign rsp.peak_count = FIELD_BITS'(peak_count_reg);
    assign rsp.peak_bin   = FIELD_BITS'(peak_bin_reg);

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.finish, cmd.sweep}))
        else $error("datapath commands overlap");

    a_peak_bounds_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.finish) |-> (peak_count_reg >= res_count_reg))
        else $error("bin count above peak count");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_done |=> (peak_count_reg == '0) && (peak_bin_reg == '0)
            && (res_count_reg == '0) && (addr_reg == '0))
        else $error("clear left state behind");

endmodule

// ===== tb/pixel_histogram_with_mode_top_tb.sv =====
`timescale 1ns / 1ps

module pixel_histogram_with_mode_top_tb;
    import phm_pkg::*;

    localparam kind_t  KIND_UNUSED = 2'd3;
    localparam int     RAND_ITEMS  = 1900;
    localparam int     CHUNK       = 100;
    localparam int     MAX_CLEARS  = 2;
    localparam int     TAIL_CYCLES = 20;
    localparam int     MAX_PRINTS  = 50;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        req_t rq;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic [COUNT_BITS-1:0] bin_model [int];
    logic [COUNT_BITS-1:0] peak_cnt_m = '0;
    logic [PIXEL_BITS-1:0] peak_bin_m = '0;
    rsp_t                  pending_rsp [$];
    dir_row_t              dir_tab [$];
    bit                    no_idle = 1'b0;
    int                    errors  = 0;
    longint                cycles  = 0;

    pixel_histogram_with_mode_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        if (errors < MAX_PRINTS)
            $display("mismatch %0s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [COUNT_BITS-1:0] bin_of(input logic [PIXEL_BITS-1:0] idx);
        return bin_model.exists(int'(idx)) ? bin_model[int'(idx)] : '0;
    endfunction

    function automatic rsp_t hist_predict(input req_t r);
        rsp_t                  o;
        logic [PIXEL_BITS-1:0] idx;
        logic [COUNT_BITS-1:0] c;
        idx = r.value[PIXEL_BITS-1:0];
        c   = '0;
        case (r.kind)
            KIND_CLEAR:
            begin
                bin_model.delete();
                peak_cnt_m = '0;
                peak_bin_m = '0;
            end
            KIND_PIXEL:
            begin
                c = bin_of(idx);
                if (c != COUNT_MAX)
                begin
                    c = c + COUNT_BITS'(1);
                    bin_model[int'(idx)] = c;
                    if (c > peak_cnt_m)
                    begin
                        peak_cnt_m = c;
                        peak_bin_m = idx;
                    end
                end
            end
            KIND_READ:
                c = bin_of(idx);
            default:
                c = '0;
        endcase
        o.bin_count  = FIELD_BITS'(c);
        o.peak_count = FIELD_BITS'(peak_cnt_m);
        o.peak_bin   = FIELD_BITS'(peak_bin_m);
        return o;
    endfunction

    function automatic req_t mk_req(input kind_t k, input logic [FIELD_BITS-1:0] v);
        req_t r;
        r.kind  = k;
        r.value = v;
        return r;
    endfunction

    task automatic add_row(input kind_t k, input logic [FIELD_BITS-1:0] v, input bit typed,
                           input logic [FIELD_BITS-1:0] bc, input logic [FIELD_BITS-1:0] pc,
                           input logic [FIELD_BITS-1:0] pb);
        dir_row_t row;
        row.rq              = mk_req(k, v);
        row.typed           = typed;
        row.want.bin_count  = bc;
        row.want.peak_count = pc;
        row.want.peak_bin   = pb;
        dir_tab.push_back(row);
    endtask

    task automatic send_req(input req_t rq, input bit typed, input rsp_t want);
        int   gap;
        rsp_t pred;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= rq;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        pred = hist_predict(rq);
        pending_rsp.push_back(typed ? want : pred);
    endtask

    // response side: random stall after each accepted response
    initial
    begin
        int   hold_left;
        rsp_t exp_rsp;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    report_mismatch("response with none pending", rsp, '0);
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    if (rsp.bin_count !== exp_rsp.bin_count)
                        report_mismatch("bin_count", 48'(rsp.bin_count),
                                        48'(exp_rsp.bin_count));
                    if (rsp.peak_count !== exp_rsp.peak_count)
                        report_mismatch("peak_count", 48'(rsp.peak_count),
                                        48'(exp_rsp.peak_count));
                    if (rsp.peak_bin !== exp_rsp.peak_bin)
                        report_mismatch("peak_bin", 48'(rsp.peak_bin),
                                        48'(exp_rsp.peak_bin));
                end
                hold_left = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int                    n_clears;
        int                    hot_base;
        int                    r;
        int                    s;
        kind_t                 k;
        logic [FIELD_BITS-1:0] v;
        rsp_t                  none;

        none     = '0;
        n_clears = 0;

        // empty store after reset, extremes, ties and the unused kind
        add_row(KIND_READ,   16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        add_row(KIND_READ,   16'hffff, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        add_row(KIND_UNUSED, 16'hffff, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        add_row(KIND_PIXEL,  16'hffff, 1'b1, 16'h0001, 16'h0001, 16'hffff);
        add_row(KIND_PIXEL,  16'h0000, 1'b1, 16'h0001, 16'h0001, 16'hffff);
        add_row(KIND_PIXEL,  16'h0000, 1'b1, 16'h0002, 16'h0002, 16'h0000);
        add_row(KIND_READ,   16'hffff, 1'b1, 16'h0001, 16'h0002, 16'h0000);
        add_row(KIND_UNUSED, 16'h0000, 1'b1, 16'h0000, 16'h0002, 16'h0000);
        add_row(KIND_PIXEL,  16'h5555, 1'b0, '0, '0, '0);
        add_row(KIND_PIXEL,  16'haaaa, 1'b0, '0, '0, '0);
        add_row(KIND_PIXEL,  16'h5555, 1'b0, '0, '0, '0);
        add_row(KIND_PIXEL,  16'h5555, 1'b0, '0, '0, '0);
        add_row(KIND_READ,   16'h5555, 1'b0, '0, '0, '0);
        add_row(KIND_READ,   16'haaaa, 1'b0, '0, '0, '0);
        add_row(KIND_PIXEL,  16'h8000, 1'b0, '0, '0, '0);
        add_row(KIND_PIXEL,  16'h7fff, 1'b0, '0, '0, '0);
        add_row(KIND_READ,   16'h1234, 1'b0, '0, '0, '0);
        add_row(KIND_CLEAR,  16'hffff, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        add_row(KIND_READ,   16'h5555, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        add_row(KIND_READ,   16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        add_row(KIND_PIXEL,  16'h5555, 1'b1, 16'h0001, 16'h0001, 16'h5555);
        add_row(KIND_PIXEL,  16'h0001, 1'b0, '0, '0, '0);
        add_row(KIND_PIXEL,  16'h0001, 1'b0, '0, '0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);

        hot_base = $urandom_range(0, 65535 - 8);
        for (int c = 0; c < RAND_ITEMS / CHUNK; c++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < CHUNK; i++)
            begin
                r = $urandom_range(0, 99);
                s = $urandom_range(0, 9);
                if (s < 6)
                    v = FIELD_BITS'(hot_base + $urandom_range(0, 7));
                else if (s == 6)
                    v = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                else
                    v = FIELD_BITS'($urandom);
                if (r == 0 && n_clears < MAX_CLEARS && $urandom_range(0, 9) == 0)
                begin
                    k = KIND_CLEAR;
                    n_clears++;
                end
                else if (r < 60)
                begin
                    k = KIND_PIXEL;
                end
                else if (r < 95)
                begin
                    k = KIND_READ;
                end
                else
                begin
                    k = KIND_UNUSED;
                end
                send_req(mk_req(k, v), 1'b0, none);
            end

            if (c == 5)
            begin
                // sender holds off until every response is back
                req_valid <= 1'b0;
                while (pending_rsp.size() != 0)
                    @(posedge clk);
            end
        end

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
